[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BCLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define BCLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/bclp_pkg.sv]
// ----------------------------------------------------------------------------
// bclp_pkg
// Types and constants for the button click and long press classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bclp_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_HIGH  = 2'd3;

  localparam logic [CFG_W-1:0] RST_FILTER_COUNT = 16'd0;
  localparam logic [CFG_W-1:0] RST_LONG_LIMIT   = 16'd600;
  localparam logic [CFG_W-1:0] RST_DOUBLE_LOW   = 16'd50;
  localparam logic [CFG_W-1:0] RST_DOUBLE_HIGH  = 16'd500;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] filter_count;
    logic [CFG_W-1:0] long_limit;
    logic [CFG_W-1:0] double_low;
    logic [CFG_W-1:0] double_high;
  } cfg_t;

endpackage

[rtl/bclp_in_if.sv]
// ----------------------------------------------------------------------------
// bclp_in_if
// Input channel carrying one sampled button level per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bclp_in_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

[rtl/bclp_out_if.sv]
// ----------------------------------------------------------------------------
// bclp_out_if
// Result channel carrying one event code per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bclp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

[rtl/bclp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bclp_cfg_regs
// Configuration register file for the timing limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bclp_cfg_regs
  import bclp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_count <= RST_FILTER_COUNT;
      cfg_r.long_limit   <= RST_LONG_LIMIT;
      cfg_r.double_low   <= RST_DOUBLE_LOW;
      cfg_r.double_high  <= RST_DOUBLE_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_COUNT: cfg_r.filter_count <= cfg_wdata;
        CFG_LONG_LIMIT:   cfg_r.long_limit   <= cfg_wdata;
        CFG_DOUBLE_LOW:   cfg_r.double_low   <= cfg_wdata;
        CFG_DOUBLE_HIGH:  cfg_r.double_high  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/bclp_classify.sv]
// ----------------------------------------------------------------------------
// bclp_classify
// Held and release counters with prescalers and the event decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bclp_classify
  import bclp_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   step,
  input  logic   key_level,
  input  cfg_t   cfg,
  output event_t ev
);

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  logic [COUNT_WIDTH-1:0] held_cnt_r, held_cnt_nxt;
  logic [COUNT_WIDTH-1:0] rel_cnt_r, rel_cnt_nxt;
  logic [COUNT_WIDTH-1:0] held_pre_r, held_pre_nxt;
  logic [COUNT_WIDTH-1:0] rel_pre_r, rel_pre_nxt;
  logic                   seen_r, seen_nxt;
  logic                   wait_r, wait_nxt;
  logic [CMP_W-1:0]       filt_ext, long_ext, dlow_ext, dhigh_ext;

  assign filt_ext  = CMP_W'(cfg.filter_count);
  assign long_ext  = CMP_W'(cfg.long_limit);
  assign dlow_ext  = CMP_W'(cfg.double_low);
  assign dhigh_ext = CMP_W'(cfg.double_high);

  always_comb begin
    held_cnt_nxt = held_cnt_r;
    rel_cnt_nxt  = rel_cnt_r;
    held_pre_nxt = held_pre_r;
    rel_pre_nxt  = rel_pre_r;
    seen_nxt     = seen_r;
    wait_nxt     = wait_r;
    ev           = EV_NONE;

    if (wait_r) begin
      seen_nxt     = 1'b0;
      held_cnt_nxt = '0;
      rel_cnt_nxt  = '0;
      held_pre_nxt = '0;
      rel_pre_nxt  = '0;
      if (key_level) begin
        wait_nxt = 1'b0;
      end
    end

    if (!key_level && !wait_nxt) begin
      seen_nxt     = 1'b1;
      held_pre_nxt = held_pre_nxt + COUNT_WIDTH'(1);
      if (CMP_W'(held_pre_nxt) > filt_ext) begin
        held_pre_nxt = '0;
        held_cnt_nxt = held_cnt_nxt + COUNT_WIDTH'(1);
      end
    end

    if (CMP_W'(held_cnt_nxt) > long_ext) begin
      wait_nxt = 1'b1;
      ev       = EV_LONG;
    end else begin
      if (seen_nxt && key_level) begin
        rel_pre_nxt = rel_pre_nxt + COUNT_WIDTH'(1);
        if (CMP_W'(rel_pre_nxt) > filt_ext) begin
          rel_pre_nxt = '0;
          rel_cnt_nxt = rel_cnt_nxt + COUNT_WIDTH'(1);
        end
      end
      if (seen_nxt && CMP_W'(rel_cnt_nxt) > dlow_ext &&
          CMP_W'(rel_cnt_nxt) < dhigh_ext) begin
        if (!key_level) begin
          wait_nxt = 1'b1;
          ev       = EV_DOUBLE;
        end
      end else if (seen_nxt && CMP_W'(rel_cnt_nxt) > dhigh_ext) begin
        wait_nxt = 1'b1;
        ev       = EV_SINGLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
      rel_cnt_r  <= '0;
      held_pre_r <= '0;
      rel_pre_r  <= '0;
      seen_r     <= 1'b0;
      wait_r     <= 1'b0;
    end else if (step) begin
      held_cnt_r <= held_cnt_nxt;
      rel_cnt_r  <= rel_cnt_nxt;
      held_pre_r <= held_pre_nxt;
      rel_pre_r  <= rel_pre_nxt;
      seen_r     <= seen_nxt;
      wait_r     <= wait_nxt;
    end
  end

endmodule

[rtl/button_click_long_press_classifier_core.sv]
// ----------------------------------------------------------------------------
// button_click_long_press_classifier_core
// Classifies sampled button levels into single click, double click and
// long press events.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload           Width
// in_ch     in   key_level         1
// out_ch    out  event_code        2
// cfg_*     in   index, wdata      2, 16
//
// One beat is accepted per cycle while the result channel does not stall;
// each beat yields one result through the input and result registers.
// The counter update and the decision are one pass of compare and increment.
// Reset is synchronous and loads the default limits and clears all counters.
// A stalled result holds its register; a new beat is still taken while the
// input register can move on in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module button_click_long_press_classifier_core
  import bclp_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bclp_in_if.sink              in_ch,
  bclp_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t   cfg;
  event_t ev;
  event_t out_code_r;
  logic   s1_valid_r;
  logic   s1_level_r;
  logic   out_valid_r;
  logic   advance;
  logic   step;

  bclp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bclp_classify #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .key_level (s1_level_r),
    .cfg       (cfg),
    .ev        (ev)
  );

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_level_r <= in_ch.key_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_code_r <= ev;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_code = out_code_r;

  `BCLP_ASSERT_NEXT(a_step_fills_out, step, out_valid_r && out_ch.event_code == $past(ev))
  `BCLP_ASSERT_NOW(a_stall_only_when_full, !in_ch.ready, s1_valid_r && out_valid_r)
  `BCLP_ASSERT_NOW(a_double_on_press, step && ev == EV_DOUBLE, !s1_level_r)

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button click and long press classifier. Level
// beats go in through the input channel, and a scoreboard predicts the event
// code that each beat must produce. Results are checked in order on the
// result channel under random sender and receiver idling. Runs cover the
// reset limits, all-zero and all-ones limits and random small limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import bclp_pkg::*;
();

  localparam int CNT_W = 16;

  class press_scoreboard;
    cfg_t             lim;
    logic [CNT_W-1:0] rel_cnt;
    logic [CNT_W-1:0] held_cnt;
    logic [CNT_W-1:0] held_pre;
    logic [CNT_W-1:0] rel_pre;
    bit               pressed_seen;
    bit               wait_release;
    event_t           expected_q[$];
    int unsigned      errors;

    function new();
      lim.filter_count = RST_FILTER_COUNT;
      lim.long_limit   = RST_LONG_LIMIT;
      lim.double_low   = RST_DOUBLE_LOW;
      lim.double_high  = RST_DOUBLE_HIGH;
      rel_cnt = '0;
      held_cnt = '0;
      held_pre = '0;
      rel_pre = '0;
      pressed_seen = 1'b0;
      wait_release = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_FILTER_COUNT: lim.filter_count = val;
        CFG_LONG_LIMIT:   lim.long_limit = val;
        CFG_DOUBLE_LOW:   lim.double_low = val;
        CFG_DOUBLE_HIGH:  lim.double_high = val;
        default: ;
      endcase
    endfunction

    function void note_key(bit released);
      event_t ev;
      ev = EV_NONE;
      if (wait_release) begin
        pressed_seen = 1'b0;
        rel_cnt = '0;
        held_cnt = '0;
        held_pre = '0;
        rel_pre = '0;
        if (released) wait_release = 1'b0;
      end
      if (!released && !wait_release) begin
        pressed_seen = 1'b1;
        held_pre = held_pre + CNT_W'(1);
        if (held_pre > lim.filter_count) begin
          held_pre = '0;
          held_cnt = held_cnt + CNT_W'(1);
        end
      end
      if (held_cnt > lim.long_limit) begin
        wait_release = 1'b1;
        ev = EV_LONG;
      end else begin
        if (pressed_seen && released) begin
          rel_pre = rel_pre + CNT_W'(1);
          if (rel_pre > lim.filter_count) begin
            rel_pre = '0;
            rel_cnt = rel_cnt + CNT_W'(1);
          end
        end
        if (pressed_seen && rel_cnt > lim.double_low && rel_cnt < lim.double_high) begin
          if (!released) begin
            wait_release = 1'b1;
            ev = EV_DOUBLE;
          end
        end else if (pressed_seen && rel_cnt > lim.double_high) begin
          wait_release = 1'b1;
          ev = EV_SINGLE;
        end
      end
      expected_q.push_back(ev);
    endfunction

    function void check_event(logic [1:0] code);
      event_t exp_ev;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result beat: event_code %0d", code);
        return;
      end
      exp_ev = expected_q.pop_front();
      if (code !== exp_ev) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: event_code expected %0d (%s), got %0d",
                   exp_ev, exp_ev.name(), code);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int unsigned          send_idle;
  int unsigned          recv_idle;
  press_scoreboard      sb;

  bclp_in_if  in_ch ();
  bclp_out_if out_ch ();

  button_click_long_press_classifier_core #(
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_event(out_ch.event_code);
  end

  task automatic send_level(bit lvl);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.key_level <= lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_key(lvl);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_limits(logic [CFG_W-1:0] f, logic [CFG_W-1:0] l,
                            logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    write_reg(CFG_FILTER_COUNT, f);
    write_reg(CFG_LONG_LIMIT, l);
    write_reg(CFG_DOUBLE_LOW, lo);
    write_reg(CFG_DOUBLE_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  // Alternating press and release runs sized from the current limits, with
  // occasional single-beat glitches mixed in.
  task automatic run_phase(int unsigned n_items);
    int unsigned       sent;
    int unsigned       run;
    longint unsigned   scale;
    longint unsigned   cap;
    bit                lvl;
    sent  = 0;
    lvl   = 1'b0;
    scale = longint'(sb.lim.filter_count) + 1;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_level(1'($urandom_range(0, 1)));
        sent++;
      end else begin
        if (lvl == 1'b0) cap = (longint'(sb.lim.long_limit) + 2) * scale;
        else cap = (longint'(sb.lim.double_high) + 2) * scale;
        if (cap > 48) cap = 48;
        run = $urandom_range(1, int'(cap));
        repeat (run) send_level(lvl);
        sent += run;
        lvl = ~lvl;
      end
    end
  endtask

  initial begin
    bit default_seq[$];
    bit small_seq[$];
    sb = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.key_level <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_FILTER_COUNT;
    cfg_wdata       <= '0;
    send_idle = 15;
    recv_idle = 66;
    default_seq = '{1, 0, 1, 0, 0, 1};
    // Long press, early re-press then double click, then a single click that
    // passes through a release count equal to the upper limit.
    small_seq = '{0, 0, 0, 0, 0, 1,
                  0, 1, 0, 1, 1, 0, 1,
                  0, 1, 1, 1, 1, 1, 1};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (default_seq[i]) send_level(default_seq[i]);
    drain();
    set_limits(16'd0, 16'd3, 16'd1, 16'd4);
    foreach (small_seq[i]) send_level(small_seq[i]);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 4) begin
        send_idle = 15;
        recv_idle = 66;
      end else if (ph < 8) begin
        send_idle = 66;
        recv_idle = 15;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ph)
        0: set_limits(16'd0, 16'd0, 16'd0, 16'd0);
        1: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_limits(16'd0, 16'hFFFF, 16'd0, 16'($urandom_range(10, 30)));
        default: set_limits(16'($urandom_range(0, 3)), 16'($urandom_range(1, 24)),
                            16'($urandom_range(0, 6)), 16'($urandom_range(0, 16)));
      endcase
      run_phase(125);
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
